@@ src/wta_pkg.sv @@
// Package for the window threshold alarm monitor.
// Holds field widths, stream packing offsets and zone codes.
// No dependencies; used by the top level and its checker.
`default_nettype none

package wta_pkg;

    // Field widths.
    localparam int IDX_W  = 6;
    localparam int VAL_W  = 32;
    localparam int CODE_W = 16;
    localparam int ZONE_W = 2;

    typedef logic [ZONE_W-1:0] t_zone;

    // Zone codes.
    localparam t_zone ZONE_NORMAL = 2'd0;
    localparam t_zone ZONE_ABOVE  = 2'd1;
    localparam t_zone ZONE_BELOW  = 2'd2;

    // Slave-side packing: tuser carries the sensor index, tdata the rest.
    localparam int S_TUSER_W   = IDX_W;
    localparam int S_VALUE_LSB = 0;
    localparam int S_UPPER_LSB = S_VALUE_LSB + VAL_W;
    localparam int S_LOWER_LSB = S_UPPER_LSB + VAL_W;
    localparam int S_UCODE_LSB = S_LOWER_LSB + VAL_W;
    localparam int S_LCODE_LSB = S_UCODE_LSB + CODE_W;
    localparam int S_NCODE_LSB = S_LCODE_LSB + CODE_W;
    localparam int S_TDATA_W   = S_NCODE_LSB + CODE_W;

    // Master-side packing: tuser carries the sensor id, tdata the rest.
    localparam int M_TUSER_W   = IDX_W;
    localparam int M_ZONE_LSB  = 0;
    localparam int M_CODE_LSB  = M_ZONE_LSB + ZONE_W;
    localparam int M_ALARM_BIT = M_CODE_LSB + CODE_W;
    localparam int M_HLTH_BIT  = M_ALARM_BIT + 1;
    localparam int M_USED_W    = M_HLTH_BIT + 1;
    localparam int M_TDATA_W   = ((M_USED_W + 7) / 8) * 8;

endpackage

`default_nettype wire

@@ src/window_threshold_alarm_monitor.sv @@
// Top level of the window threshold alarm monitor: compare, zone memory,
// alarm count and output register. Depends on wta_pkg.
`default_nettype none

// Channel   Dir  Handshake                 tuser         tdata
// s_axis    in   i_s_axis_tvalid/o_tready  sensor_index  value, upper, lower, codes
// m_axis    out  o_m_axis_tvalid/i_tready  sensor_id     zone, code, alarm, health
//
// One sample can be taken every cycle unless the clearing pass or a stalled
// output holds the input. A sample is compared against its limits in the
// cycle it is accepted while its old zone is read from the zone memory;
// the second stage then compares zones and, on a zone change only, writes
// the memory back and loads the output register, which drives tvalid.
// Forwarding of the last write-back lets samples for the same sensor follow
// each other back to back. After reset a clearing pass writes every zone
// entry to normal with o_s_axis_tready low. A stalled output register
// holds a zone change in the second stage, which then holds the input.

module window_threshold_alarm_monitor #(
    parameter int SENSOR_COUNT = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Slave side.
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata from bit 0: value, upper_limit, lower_limit, upper_code,
    // lower_code, normal_code.
    input  wire logic [wta_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser from bit 0: sensor_index.
    input  wire logic [wta_pkg::S_TUSER_W-1:0]  i_s_axis_tuser,
    // Master side.
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // tdata from bit 0: new_zone, reaction_code, alarm_active,
    // health_update, then zero padding.
    output logic [wta_pkg::M_TDATA_W-1:0]       o_m_axis_tdata,
    // tuser from bit 0: sensor_id.
    output logic [wta_pkg::M_TUSER_W-1:0]       o_m_axis_tuser
);

    // Memory address width and alarm counter width follow the sensor count.
    localparam int AW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int CW = $clog2(SENSOR_COUNT + 1);

    // Zone memory: one entry per sensor, synchronous read and write.
    wta_pkg::t_zone r_zone_mem [SENSOR_COUNT];

    // Clearing pass after reset.
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    // Stage one: the accepted sample's zone, selected code and read data.
    logic                         r_s1_valid;
    logic [AW-1:0]                r_s1_addr;
    logic [wta_pkg::IDX_W-1:0]    r_s1_idx;
    wta_pkg::t_zone               r_s1_zone;
    logic [wta_pkg::CODE_W-1:0]   r_s1_code;
    wta_pkg::t_zone               r_rdata;

    // Forwarding of the last write-back, which the memory read of the
    // following sample cannot see yet.
    logic           r_fwd_valid;
    logic [AW-1:0]  r_fwd_addr;
    wta_pkg::t_zone r_fwd_zone;

    // Global alarm state.
    logic [CW-1:0] r_count;
    logic          r_alarm;
    logic [CW-1:0] n_count;
    logic          n_alarm;

    // Output register.
    logic                        r_out_valid;
    logic [wta_pkg::IDX_W-1:0]   r_out_id;
    wta_pkg::t_zone              r_out_zone;
    logic [wta_pkg::CODE_W-1:0]  r_out_code;
    logic                        r_out_alarm;
    logic                        r_out_health;

    // Input field views.
    logic signed [wta_pkg::VAL_W-1:0] w_value;
    logic signed [wta_pkg::VAL_W-1:0] w_upper;
    logic signed [wta_pkg::VAL_W-1:0] w_lower;
    logic [wta_pkg::CODE_W-1:0]       w_ucode;
    logic [wta_pkg::CODE_W-1:0]       w_lcode;
    logic [wta_pkg::CODE_W-1:0]       w_ncode;
    logic [wta_pkg::IDX_W-1:0]        w_idx;
    logic [AW-1:0]                    w_addr;
    logic                             w_in_range;
    wta_pkg::t_zone                   w_zone;
    logic [wta_pkg::CODE_W-1:0]       w_code;

    logic           w_s_acc;
    wta_pkg::t_zone w_old_zone;
    logic           w_changed;
    logic           w_health;
    logic           w_s1_go;

    assign w_value = i_s_axis_tdata[wta_pkg::S_VALUE_LSB +: wta_pkg::VAL_W];
    assign w_upper = i_s_axis_tdata[wta_pkg::S_UPPER_LSB +: wta_pkg::VAL_W];
    assign w_lower = i_s_axis_tdata[wta_pkg::S_LOWER_LSB +: wta_pkg::VAL_W];
    assign w_ucode = i_s_axis_tdata[wta_pkg::S_UCODE_LSB +: wta_pkg::CODE_W];
    assign w_lcode = i_s_axis_tdata[wta_pkg::S_LCODE_LSB +: wta_pkg::CODE_W];
    assign w_ncode = i_s_axis_tdata[wta_pkg::S_NCODE_LSB +: wta_pkg::CODE_W];
    assign w_idx   = i_s_axis_tuser[wta_pkg::IDX_W-1:0];
    assign w_addr  = AW'(w_idx);

    // Samples for sensors beyond the table are taken and dropped.
    assign w_in_range = (int'(w_idx) < SENSOR_COUNT);

    // Window compare; with crossed limits the upper compare wins.
    always_comb begin
        if (w_value >= w_upper) begin
            w_zone = wta_pkg::ZONE_ABOVE;
            w_code = w_ucode;
        end else if (w_value <= w_lower) begin
            w_zone = wta_pkg::ZONE_BELOW;
            w_code = w_lcode;
        end else begin
            w_zone = wta_pkg::ZONE_NORMAL;
            w_code = w_ncode;
        end
    end

    // Stage two: zone change detection and alarm bookkeeping.
    always_comb begin
        if (r_fwd_valid && (r_fwd_addr == r_s1_addr)) begin
            w_old_zone = r_fwd_zone;
        end else begin
            w_old_zone = r_rdata;
        end
        w_changed = (r_s1_zone != w_old_zone);
        n_count   = r_count;
        n_alarm   = r_alarm;
        w_health  = 1'b0;
        if (r_s1_zone != wta_pkg::ZONE_NORMAL) begin
            // Moving between above and below leaves the count alone.
            if (w_old_zone == wta_pkg::ZONE_NORMAL) begin
                n_count = r_count + CW'(1);
            end
            if (!r_alarm) begin
                n_alarm  = 1'b1;
                w_health = 1'b1;
            end
        end else begin
            if (r_count != '0) begin
                n_count = r_count - CW'(1);
            end
            if (r_alarm) begin
                n_alarm  = (n_count != '0);
                w_health = 1'b1;
            end
        end
    end

    // Stage two completes unless it has a result and the output is blocked.
    assign w_s1_go = r_s1_valid && (!w_changed || !r_out_valid || i_m_axis_tready);

    assign o_s_axis_tready = !r_clr_busy && (!r_s1_valid || w_s1_go);
    assign w_s_acc         = i_s_axis_tvalid && o_s_axis_tready;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_count     <= '0;
            r_alarm     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(SENSOR_COUNT - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (w_s_acc) begin
                r_s1_valid <= w_in_range;
            end else if (w_s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_go) begin
                r_fwd_valid <= 1'b1;
            end
            if (w_s1_go && w_changed) begin
                r_count     <= n_count;
                r_alarm     <= n_alarm;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_s1_addr <= w_addr;
            r_s1_idx  <= w_idx;
            r_s1_zone <= w_zone;
            r_s1_code <= w_code;
        end
        if (w_s1_go) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_zone <= r_s1_zone;
        end
        if (w_s1_go && w_changed) begin
            r_out_id     <= r_s1_idx;
            r_out_zone   <= r_s1_zone;
            r_out_code   <= r_s1_code;
            r_out_alarm  <= n_alarm;
            r_out_health <= w_health;
        end
    end

    // Zone memory: the clearing pass owns the write port until it ends.
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_zone_mem[r_clr_addr] <= wta_pkg::ZONE_NORMAL;
        end else if (w_s1_go && w_changed) begin
            r_zone_mem[r_s1_addr] <= r_s1_zone;
        end
        if (w_s_acc) begin
            r_rdata <= r_zone_mem[w_addr];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_id;
    always_comb begin
        o_m_axis_tdata = '0;
        o_m_axis_tdata[wta_pkg::M_ZONE_LSB +: wta_pkg::ZONE_W] = r_out_zone;
        o_m_axis_tdata[wta_pkg::M_CODE_LSB +: wta_pkg::CODE_W] = r_out_code;
        o_m_axis_tdata[wta_pkg::M_ALARM_BIT] = r_out_alarm;
        o_m_axis_tdata[wta_pkg::M_HLTH_BIT]  = r_out_health;
    end

endmodule

`default_nettype wire

@@ src/wta_checker.sv @@
// Port-level checker for the window threshold alarm monitor, with its bind.
// Depends on wta_pkg.
`default_nettype none

module wta_port_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_s_axis_tvalid,
    input wire logic                           o_s_axis_tready,
    input wire logic [wta_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    input wire logic [wta_pkg::S_TUSER_W-1:0]  i_s_axis_tuser,
    input wire logic                           o_m_axis_tvalid,
    input wire logic                           i_m_axis_tready,
    input wire logic [wta_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    input wire logic [wta_pkg::M_TUSER_W-1:0]  o_m_axis_tuser
);

    logic [wta_pkg::ZONE_W-1:0] w_zone;
    logic                       w_alarm;
    logic                       w_health;

    assign w_zone   = o_m_axis_tdata[wta_pkg::M_ZONE_LSB +: wta_pkg::ZONE_W];
    assign w_alarm  = o_m_axis_tdata[wta_pkg::M_ALARM_BIT];
    assign w_health = o_m_axis_tdata[wta_pkg::M_HLTH_BIT];

    // A stalled result transaction keeps its content.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // Entering an alarm zone always leaves the global flag set.
    a_alarm_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (w_zone != wta_pkg::ZONE_NORMAL) |-> w_alarm)
        else $error("alarm zone reported with flag clear");

    // The flag only clears on a return to normal, which is always a health event.
    a_alarm_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !w_alarm |-> (w_zone == wta_pkg::ZONE_NORMAL) && w_health)
        else $error("flag cleared without a health return to normal");

    // Reset empties the output and starts the clearing pass.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready && !o_m_axis_tvalid)
        else $error("not quiet after reset");

endmodule

bind window_threshold_alarm_monitor wta_port_checker u_wta_port_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

@@ dv/wta_checker.sv @@
// Checker for the window threshold alarm monitor: watches both stream channels,
// predicts each zone change from the accepted samples and compares the results.
// Depends on wta_pkg for field widths, packing offsets and zone codes.
`timescale 1ns / 1ps

module wta_checker #(
    parameter int SENSOR_COUNT = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    input  wire logic                           i_s_axis_tready,
    input  wire logic [wta_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    input  wire logic [wta_pkg::S_TUSER_W-1:0]  i_s_axis_tuser,
    input  wire logic                           i_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    input  wire logic [wta_pkg::M_TDATA_W-1:0]  i_m_axis_tdata,
    input  wire logic [wta_pkg::M_TUSER_W-1:0]  i_m_axis_tuser,
    output int                                  o_pending,
    output int                                  o_errors
);
    import wta_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0]  sensor_id;
        t_zone             zone;
        logic [CODE_W-1:0] code;
        logic              alarm;
        logic              health;
    } t_zone_event;

    // Shadow of the block's state.
    t_zone       zone_mem [SENSOR_COUNT];
    int unsigned alarmed_sensors;
    bit          alarm_on;

    t_zone_event pending_events [$];
    int          error_count = 0;

    // Returns 1 when the sample moves its sensor into another zone.
    function automatic bit predict_zone_change(input logic [IDX_W-1:0] idx,
                                               input logic [S_TDATA_W-1:0] data,
                                               output t_zone_event ev);
        logic signed [VAL_W-1:0] sample;
        logic signed [VAL_W-1:0] upper;
        logic signed [VAL_W-1:0] lower;
        logic [CODE_W-1:0]       code;
        t_zone                   zone;
        t_zone                   prev;
        bit                      health;

        sample = data[S_VALUE_LSB +: VAL_W];
        upper  = data[S_UPPER_LSB +: VAL_W];
        lower  = data[S_LOWER_LSB +: VAL_W];
        health = 1'b0;
        ev     = '0;

        if (idx >= SENSOR_COUNT)
            return 1'b0;

        // The upper compare wins when the limits are crossed.
        if (sample >= upper)
            zone = ZONE_ABOVE;
        else if (sample <= lower)
            zone = ZONE_BELOW;
        else
            zone = ZONE_NORMAL;

        prev = zone_mem[idx];
        if (zone == prev)
            return 1'b0;
        zone_mem[idx] = zone;

        if (zone != ZONE_NORMAL) begin
            if (prev == ZONE_NORMAL)
                alarmed_sensors++;
            if (!alarm_on) begin
                alarm_on = 1'b1;
                health   = 1'b1;
            end
            code = (zone == ZONE_ABOVE) ? data[S_UCODE_LSB +: CODE_W]
                                        : data[S_LCODE_LSB +: CODE_W];
        end else begin
            if (alarmed_sensors > 0)
                alarmed_sensors--;
            if (alarm_on) begin
                if (alarmed_sensors == 0)
                    alarm_on = 1'b0;
                health = 1'b1;
            end
            code = data[S_NCODE_LSB +: CODE_W];
        end

        ev.sensor_id = idx;
        ev.zone      = zone;
        ev.code      = code;
        ev.alarm     = alarm_on;
        ev.health    = health;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_zone_event want;
        t_zone_event fresh;

        if (!i_rst_n) begin
            for (int i = 0; i < SENSOR_COUNT; i++)
                zone_mem[i] = ZONE_NORMAL;
            alarmed_sensors = 0;
            alarm_on        = 1'b0;
            pending_events.delete();
        end else begin
            // A result is never caused by the sample accepted at the same edge,
            // so the compare goes first.
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_events.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result for sensor %0d, data 0x%0h",
                             $time, i_m_axis_tuser, i_m_axis_tdata);
                end else begin
                    want = pending_events.pop_front();
                    check_field("sensor_id", want.sensor_id, i_m_axis_tuser);
                    check_field("new_zone", want.zone,
                                i_m_axis_tdata[M_ZONE_LSB +: ZONE_W]);
                    check_field("reaction_code", want.code,
                                i_m_axis_tdata[M_CODE_LSB +: CODE_W]);
                    check_field("alarm_active", want.alarm,
                                i_m_axis_tdata[M_ALARM_BIT]);
                    check_field("health_update", want.health,
                                i_m_axis_tdata[M_HLTH_BIT]);
                    check_field("padding", 0, i_m_axis_tdata >> M_USED_W);
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                if (predict_zone_change(i_s_axis_tuser, i_s_axis_tdata, fresh))
                    pending_events.push_back(fresh);
            end
        end
        o_pending <= pending_events.size();
        o_errors  <= error_count;
    end

endmodule

@@ dv/tb_top.sv @@
// Top of the testbench for the window threshold alarm monitor: clock, reset,
// sample stimulus, result back-pressure and the verdict.
// Depends on wta_pkg, window_threshold_alarm_monitor and wta_checker.
`timescale 1ns / 1ps

module tb_top;
    import wta_pkg::*;

    localparam int SENSORS     = 64;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic signed [VAL_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] Q_MIN = 32'h8000_0000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] i_s_axis_tuser = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    logic [M_TUSER_W-1:0] o_m_axis_tuser;

    int          pending;
    int          errors;
    int unsigned cycle_count = 0;

    // Sender burst state and receiver stall pattern state.
    int burst_left = 0;
    int ready_mode = 0;
    int ready_left = 0;

    window_threshold_alarm_monitor #(
        .SENSOR_COUNT(SENSORS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    wta_checker #(
        .SENSOR_COUNT(SENSORS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .i_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .i_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .i_m_axis_tdata (o_m_axis_tdata),
        .i_m_axis_tuser (o_m_axis_tuser),
        .o_pending      (pending),
        .o_errors       (errors)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog. The slowest correct run is far below this limit, so hitting it
    // means the block stopped accepting samples or lost a result.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // The receiver switches between stall patterns at random: always ready, mostly
    // ready, mostly stalled, and ready only when the low three bits of cycle_count are zero.
    always @(posedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode <= $urandom_range(0, 3);
            ready_left <= $urandom_range(16, 96);
        end else begin
            ready_left <= ready_left - 1;
        end
        case (ready_mode)
            0: begin
                i_m_axis_tready <= 1'b1;
            end
            1: begin
                i_m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
            2: begin
                i_m_axis_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                i_m_axis_tready <= (cycle_count[2:0] == 3'd0);
            end
        endcase
    end

    // Offers one sample and returns at the edge where its transaction takes
    // place. Between bursts the sender drops tvalid for a random gap; a gap of
    // zero leaves tvalid high so bursts can run back to back.
    task automatic send_sample(input logic [IDX_W-1:0] idx,
                               input logic signed [VAL_W-1:0] sample,
                               input logic signed [VAL_W-1:0] upper,
                               input logic signed [VAL_W-1:0] lower,
                               input logic [CODE_W-1:0] upper_code,
                               input logic [CODE_W-1:0] lower_code,
                               input logic [CODE_W-1:0] normal_code);
        logic [S_TDATA_W-1:0] word;
        int                   gap;

        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;

        word = '0;
        word[S_VALUE_LSB +: VAL_W]  = sample;
        word[S_UPPER_LSB +: VAL_W]  = upper;
        word[S_LOWER_LSB +: VAL_W]  = lower;
        word[S_UCODE_LSB +: CODE_W] = upper_code;
        word[S_LCODE_LSB +: CODE_W] = lower_code;
        word[S_NCODE_LSB +: CODE_W] = normal_code;

        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= word;
        i_s_axis_tuser  <= idx;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Holds the sender off until every predicted zone change has come out.
    // The first wait lets the checker count the last accepted sample.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Builds one random sample. Most samples have ordered limits and a value
    // aimed at a chosen zone, often right on a limit; the rest have crossed
    // limits or fully random fields.
    task automatic random_sample(input int idx_hi);
        logic [IDX_W-1:0]  idx;
        logic [CODE_W-1:0] upper_code;
        logic [CODE_W-1:0] lower_code;
        logic [CODE_W-1:0] normal_code;
        longint            a;
        longint            b;
        longint            lower;
        longint            upper;
        longint            sample;
        longint            span;
        longint unsigned   r;
        int                pick;
        int                target;
        bit                on_limit;

        idx = IDX_W'($urandom_range(0, ($urandom_range(0, 1) != 0) ? idx_hi
                                              : ((idx_hi < 7) ? idx_hi : 7)));
        upper_code  = CODE_W'($urandom);
        lower_code  = CODE_W'($urandom);
        normal_code = CODE_W'($urandom);
        a = longint'($signed($urandom));
        b = longint'($signed($urandom));
        r = {$urandom, $urandom};
        pick     = $urandom_range(0, 9);
        on_limit = ($urandom_range(0, 3) == 0);

        if (pick >= 8) begin
            upper  = a;
            lower  = b;
            sample = longint'($signed($urandom));
        end else if (pick == 7) begin
            // Crossed limits: the upper limit is at or below the lower one.
            upper  = (a < b) ? a : b;
            lower  = (a < b) ? b : a;
            sample = ($urandom_range(0, 1) != 0) ? upper : longint'($signed($urandom));
        end else begin
            lower  = (a < b) ? a : b;
            upper  = (a < b) ? b : a;
            target = $urandom_range(0, 3);
            if (target == 2) begin
                span   = 64'sd2147483647 - upper;
                sample = on_limit ? upper : upper + longint'(r % (span + 1));
            end else if (target == 3) begin
                span   = lower + 64'sd2147483648;
                sample = on_limit ? lower : lower - longint'(r % (span + 1));
            end else if (upper - lower >= 2) begin
                if (on_limit)
                    sample = ($urandom_range(0, 1) != 0) ? lower + 1 : upper - 1;
                else
                    sample = lower + 1 + longint'(r % (upper - lower - 1));
            end else begin
                sample = upper;
            end
        end

        send_sample(idx, sample[31:0], upper[31:0], lower[31:0],
                    upper_code, lower_code, normal_code);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The block clears its zone memory after reset with
        // tready low; the first send simply waits that out.
        // Above on the exact upper limit, then a repeat that changes nothing.
        send_sample(6'd0, 32'sd1000, 32'sd1000, -32'sd1000, 16'h0001, 16'h0002, 16'h0003);
        send_sample(6'd0, 32'sd5000, 32'sd1000, -32'sd1000, 16'h0011, 16'h0012, 16'h0013);
        // Above straight to below on the exact lower limit.
        send_sample(6'd0, -32'sd1000, 32'sd1000, -32'sd1000, 16'h0021, 16'h0022, 16'h0023);
        // Second alarmed sensor at the most negative value.
        send_sample(6'd1, Q_MIN, 32'sd0, Q_MIN, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // Returns just inside both limits; the second one clears the alarm.
        send_sample(6'd0, -32'sd999, 32'sd1000, -32'sd1000, 16'h0031, 16'h0032, 16'h0033);
        send_sample(6'd1, 32'sd999, 32'sd1000, -32'sd1000, 16'h0041, 16'h0042, 16'h0043);
        // Crossed and equal limits: the upper compare wins.
        send_sample(6'd2, 32'sd5, 32'sd5, 32'sd5, 16'h0051, 16'h0052, 16'h0053);
        send_sample(6'd2, 32'sd0, -32'sd10, 32'sd10, 16'h0061, 16'h0062, 16'h0063);
        send_sample(6'd2, -32'sd20, -32'sd10, 32'sd10, 16'h0071, 16'h0072, 16'h0073);
        // Highest sensor index with the value range extremes.
        send_sample(6'd63, Q_MAX, Q_MAX, Q_MIN, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(6'd63, Q_MIN, Q_MAX, Q_MIN, 16'h0000, 16'h0000, 16'h0000);
        // An upper limit at the minimum puts every value above.
        send_sample(6'd32, Q_MIN, Q_MIN, Q_MAX, 16'hA5A5, 16'h5A5A, 16'hC3C3);
        send_sample(6'd32, Q_MAX, Q_MAX, Q_MAX, 16'h1234, 16'h5678, 16'h9ABC);
        // Everything back to normal, the last return clearing the alarm.
        send_sample(6'd2, 32'sd0, 32'sd100, -32'sd100, 16'h0081, 16'h0082, 16'h0083);
        send_sample(6'd63, 32'sd0, Q_MAX, Q_MIN, 16'h0091, 16'h0092, 16'h0093);
        send_sample(6'd32, Q_MAX - 1, Q_MAX, Q_MIN, 16'h00A1, 16'h00A2, 16'h00A3);
        // Typical Q16.16 values: 1.5 against a window of 0.5 to 1.0, then 0.75.
        send_sample(6'd5, 32'sh0001_8000, 32'sh0001_0000, 32'sh0000_8000,
                    16'h00B1, 16'h00B2, 16'h00B3);
        send_sample(6'd5, 32'sh0000_C000, 32'sh0001_0000, 32'sh0000_8000,
                    16'h00C1, 16'h00C2, 16'h00C3);
        wait_drained();

        // Random samples over all sensors, weighted toward a few busy ones.
        repeat (350) random_sample(SENSORS - 1);
        wait_drained();

        // Bring every sensor back to normal so the alarm flag clears.
        for (int i = 0; i < SENSORS; i++)
            send_sample(i[IDX_W-1:0], 32'sd0, 32'sd100, -32'sd100,
                        CODE_W'($urandom), CODE_W'($urandom), CODE_W'($urandom));

        // A few sensors only, so the alarm count returns to zero often and the
        // flag toggles many times.
        repeat (300) random_sample(3);

        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        // A short wait after the drain catches any stray result.
        repeat (8) @(posedge i_clk);

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ window_threshold_alarm_monitor.f @@
src/wta_pkg.sv
src/window_threshold_alarm_monitor.sv
src/wta_checker.sv
dv/wta_checker.sv
dv/tb_top.sv
